@@ design/edfrq_pkg.sv @@
package edfrq_pkg;

    localparam int ID_W  = 8;
    localparam int KEY_W = 16;
    localparam int CNT_W = 16;
    localparam int OP_W  = 2;
    localparam int ST_W  = 2;

    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 40;

    // opcodes
    localparam logic [OP_W-1:0] OP_INSERT   = 2'd0;
    localparam logic [OP_W-1:0] OP_SCHEDULE = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK     = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP      = 2'd3;

    // result status
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

    // id in the lowest bits, count in the highest
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [KEY_W-1:0] deadline;
        logic [ID_W-1:0]  id;
    } task_rec_t;

endpackage

@@ design/edf_ready_queue.sv @@
// channel  dir  handshake              payload
// s_*      in   s_tvalid / s_tready    s_tuser opcode, s_tdata task record
// m_*      out  m_tvalid / m_tready    m_tuser status, m_tdata scheduled task
// cfg_*    in   cfg_valid / cfg_ready  cfg_data count floor
//
// insert, no-op and refused items pass from acceptance through the done state to the result word
// schedule and tick first walk the n queued tasks from head to tail (none on an empty ring):
// the single read port of the record ram is walked once per slot, one slot a cycle
// one item at a time; a finished result waits in the output register while the
// next word is taken. reset clears the pointers and the floor, not the ram
module edf_ready_queue
    import edfrq_pkg::*;
#(
    parameter int QUEUE_SLOTS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // task_id, deadline, period, start_count
    input  logic [OP_W-1:0]       s_tuser,   // opcode
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // out_id, out_deadline, out_count
    output logic [ST_W-1:0]       m_tuser,   // status
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CNT_W-1:0]      cfg_data
);

    localparam int PTR_W = $clog2(QUEUE_SLOTS);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_SLOTS - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_TICK = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        ring_next = (p == LAST_SLOT) ? '0 : p + 1'b1;
    endfunction

    logic [1:0]       state_reg;
    logic [PTR_W-1:0] head_ptr_reg;
    logic [PTR_W-1:0] tail_ptr_reg;
    logic [PTR_W-1:0] scan_ptr_reg;
    logic [PTR_W-1:0] pend_addr_reg;
    logic             pend_valid_reg;
    logic             first_reg;
    logic [CNT_W-1:0] count_floor_reg;
    logic             m_valid_reg;

    task_rec_t        mem [QUEUE_SLOTS];
    task_rec_t        rd_data_reg;
    task_rec_t        best_reg;
    task_rec_t        head_rec_reg;
    logic [PTR_W-1:0] best_addr_reg;
    task_rec_t        res_rec_reg;
    logic [ST_W-1:0]  res_status_reg;
    task_rec_t        out_rec_reg;
    logic [ST_W-1:0]  out_status_reg;

    logic             accept;
    logic             ring_full;
    logic             ring_empty;
    logic             issue;
    logic             walk_done;
    logic             out_load;
    logic             wr_en;
    logic [PTR_W-1:0] wr_addr;
    task_rec_t        wr_data;
    task_rec_t        in_rec;
    logic [CNT_W:0]   start_sum;
    logic             take_best;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;

    assign ring_full  = (ring_next(tail_ptr_reg) == head_ptr_reg);
    assign ring_empty = (head_ptr_reg == tail_ptr_reg);

    // walk issues reads until the scan pointer meets the tail
    assign issue     = ((state_reg == S_SCAN) || (state_reg == S_TICK))
                       && (scan_ptr_reg != tail_ptr_reg);
    assign walk_done = !issue && !pend_valid_reg;
    assign out_load  = (state_reg == S_DONE) && (!m_valid_reg || m_tready);

    assign take_best = pend_valid_reg
                       && (first_reg || (rd_data_reg.deadline < best_reg.deadline));

    always_comb
    begin
        start_sum = {1'b0, s_tdata[55:40]} + {1'b0, s_tdata[39:24]};
        in_rec.id       = s_tdata[7:0];
        in_rec.deadline = s_tdata[23:8];
        in_rec.count    = start_sum[CNT_W] ? '1 : start_sum[CNT_W-1:0];

        wr_en   = 1'b0;
        wr_addr = tail_ptr_reg;
        wr_data = in_rec;
        if (accept && (s_tuser == OP_INSERT) && !ring_full)
        begin
            wr_en = 1'b1;
        end
        else if ((state_reg == S_TICK) && pend_valid_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = pend_addr_reg;
            wr_data = rd_data_reg;
            if (rd_data_reg.count > count_floor_reg)
            begin
                wr_data.count = rd_data_reg.count - 1'b1;
            end
        end
        else if ((state_reg == S_SCAN) && walk_done)
        begin
            // the old head record moves into the slot of the popped one
            wr_en   = 1'b1;
            wr_addr = best_addr_reg;
            wr_data = head_rec_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[scan_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            head_ptr_reg    <= '0;
            tail_ptr_reg    <= '0;
            scan_ptr_reg    <= '0;
            pend_addr_reg   <= '0;
            pend_valid_reg  <= 1'b0;
            first_reg       <= 1'b0;
            count_floor_reg <= '0;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                count_floor_reg <= cfg_data;
            end

            pend_valid_reg <= issue;
            pend_addr_reg  <= scan_ptr_reg;
            if (issue)
            begin
                scan_ptr_reg <= ring_next(scan_ptr_reg);
            end
            if (pend_valid_reg)
            begin
                first_reg <= 1'b0;
            end

            if (out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        scan_ptr_reg <= head_ptr_reg;
                        first_reg    <= 1'b1;
                        if ((s_tuser == OP_INSERT) && !ring_full)
                        begin
                            tail_ptr_reg <= ring_next(tail_ptr_reg);
                            state_reg    <= S_DONE;
                        end
                        else if ((s_tuser == OP_SCHEDULE) && !ring_empty)
                        begin
                            state_reg <= S_SCAN;
                        end
                        else if (s_tuser == OP_TICK)
                        begin
                            state_reg <= S_TICK;
                        end
                        else
                        begin
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (walk_done)
                    begin
                        head_ptr_reg <= ring_next(head_ptr_reg);
                        state_reg    <= S_DONE;
                    end
                end
                S_TICK:
                begin
                    if (walk_done)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (take_best)
        begin
            best_reg      <= rd_data_reg;
            best_addr_reg <= pend_addr_reg;
        end
        if (pend_valid_reg && first_reg)
        begin
            head_rec_reg <= rd_data_reg;
        end

        if (accept)
        begin
            res_rec_reg <= '0;
            if ((s_tuser == OP_INSERT) && ring_full)
            begin
                res_status_reg <= ST_FULL;
            end
            else if ((s_tuser == OP_SCHEDULE) && ring_empty)
            begin
                res_status_reg <= ST_EMPTY;
            end
            else
            begin
                res_status_reg <= ST_OK;
            end
        end
        else if ((state_reg == S_SCAN) && walk_done)
        begin
            res_rec_reg <= best_reg;
        end

        if (out_load)
        begin
            out_rec_reg    <= res_rec_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_rec_reg;
    assign m_tuser  = out_status_reg;

`ifndef SYNTH
    a_head_moves_at_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_SCAN) |=> $stable(head_ptr_reg))
        else $error("head pointer moved outside a schedule walk");

    a_tail_moves_at_insert: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(tail_ptr_reg))
        else $error("tail pointer moved without an accepted word");

    a_pend_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> ((state_reg == S_SCAN) || (state_reg == S_TICK)))
        else $error("ram read pending outside a walk");

    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != ST_OK)) |-> (m_tdata == '0))
        else $error("refused result carries a record");
`endif

endmodule
